FILE: sv/sfdm_pkg.sv
// Shared definitions for the stereo feedback delay mix unit.
// Holds sizes, register indexes, routing codes and the rounding and saturation helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package sfdm_pkg;

  localparam int unsigned MAX_DELAY   = 262144;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ADDR_W      = $clog2(MAX_DELAY);
  localparam int unsigned DELAY_W     = 18;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_W       = 18;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int unsigned WIDE_W      = 48;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

  typedef enum logic [MODE_W-1:0] {
    MODE_MONO      = 2'd0,
    MODE_STEREO    = 2'd1,
    MODE_PING_PONG = 2'd2
  } routing_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTING_MODE  = 3'd0,
    CFG_DELAY_LEFT    = 3'd1,
    CFG_DELAY_RIGHT   = 3'd2,
    CFG_FEEDBACK_GAIN = 3'd3,
    CFG_WET_MIX       = 3'd4
  } cfg_index_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  function automatic wide_t round_q15(input wide_t x);
    return (x + wide_t'(16384)) >>> 15;
  endfunction

  function automatic sample_t sat_sample(input wide_t x);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (x > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end
    if (x < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: sv/sfdm_ram.sv
// Simple dual-port synchronous RAM used for one delay line.
// One write port and one read port with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module sfdm_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/stereo_feedback_delay_mix_unit.sv
// Top level of the stereo feedback delay mix unit.
// Holds the configuration registers, the read, modify and write-back pipeline and the mixer.
// Depends on sfdm_pkg and sfdm_ram.
`timescale 1ns / 1ps

// The unit accepts a stereo transaction only while its read stage is empty: the read step fetches
// both delay line taps from their RAMs and the write-back step then writes the new line values
// at the shared write pointer, so each RAM sees one read and at most one write per transaction.
// The result passes through the product stage into the output register, and these let a further
// transaction enter while a result waits. No clearing pass is needed after reset: until the
// write pointer first wraps, a tap that lies ahead of the pointer reads as zero, and mono
// mode writes zeros into the right line during that first pass.
module stereo_feedback_delay_mix_unit
  import sfdm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  localparam int unsigned AW1 = ADDR_W + 1;

  logic [MODE_W-1:0]  mode_q;
  logic [DELAY_W-1:0] delay_l_q;
  logic [DELAY_W-1:0] delay_r_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [GAIN_W-1:0]  mix_q;

  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              wrapped_q, wrapped_d;

  logic    s1_valid_q;
  sample_t s1_dl_q, s1_dr_q;
  logic    s1_lvalid_q, s1_rvalid_q;

  logic  s2_valid_q, s2_valid_d;
  prod_t s2_pl_dry_q, s2_pl_wet_q, s2_pr_dry_q, s2_pr_wet_q;

  logic    out_valid_q, out_valid_d;
  sample_t left_out_q, right_out_q;

  logic in_fire, s2_move;

  function automatic logic [ADDR_W-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
    if (d == '0) begin
      return ADDR_W'(1);
    end
    if (32'(d) >= MAX_DELAY) begin
      return ADDR_W'(MAX_DELAY - 1);
    end
    return ADDR_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] wp,
                                                 input logic [ADDR_W-1:0] d);
    logic [AW1-1:0] sum;
    sum = {1'b0, wp} - {1'b0, d};
    if (wp < d) begin
      sum = sum + AW1'(MAX_DELAY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MONO;
      delay_l_q <= DELAY_W'(1);
      delay_r_q <= DELAY_W'(1);
      gain_q    <= '0;
      mix_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROUTING_MODE:  mode_q    <= cfg_wdata_i[MODE_W-1:0];
        CFG_DELAY_LEFT:    delay_l_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_DELAY_RIGHT:   delay_r_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_FEEDBACK_GAIN: gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_WET_MIX:       mix_q     <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read stage: issue both tap reads at acceptance.
  logic [ADDR_W-1:0] d_l, d_r, raddr_l, raddr_r;

  assign in_ready_o = !s1_valid_q && (!s2_valid_q || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    d_l     = clamp_delay(delay_l_q);
    d_r     = clamp_delay(delay_r_q);
    raddr_l = tap_addr(wp_q, d_l);
    raddr_r = tap_addr(wp_q, d_r);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_dl_q     <= left_in_i;
      s1_dr_q     <= right_in_i;
      s1_lvalid_q <= wrapped_q || (wp_q >= d_l);
      s1_rvalid_q <= wrapped_q || (wp_q >= d_r);
    end
  end

  // Modify and write-back stage.
  logic [SAMPLE_BITS-1:0] rdata_l, rdata_r;
  logic                   is_mono, is_ping;
  logic [GAIN_W-1:0]      g, m, m_dry;
  logic signed [GAIN_W:0] g_s, m_s, m_dry_s;
  sample_t                tl, tr_raw, tr, fb_src_l, fb_src_r, wr_l, wr_r;
  prod_t                  fb_prod_l, fb_prod_r;
  wide_t                  in_l;
  logic                   we_r;

  always_comb begin
    is_ping  = (mode_q == MODE_PING_PONG);
    is_mono  = !(is_ping || (mode_q == MODE_STEREO));
    g        = (gain_q > UNITY_GAIN) ? UNITY_GAIN : gain_q;
    m        = (mix_q > UNITY_GAIN) ? UNITY_GAIN : mix_q;
    m_dry    = UNITY_GAIN - m;
    g_s      = $signed({1'b0, g});
    m_s      = $signed({1'b0, m});
    m_dry_s  = $signed({1'b0, m_dry});
    tl       = s1_lvalid_q ? $signed(rdata_l) : '0;
    tr_raw   = s1_rvalid_q ? $signed(rdata_r) : '0;
    tr       = is_mono ? tl : tr_raw;
    fb_src_l = is_ping ? tr_raw : tl;
    fb_src_r = is_ping ? tl : tr_raw;
    fb_prod_l = fb_src_l * g_s;
    fb_prod_r = fb_src_r * g_s;
    in_l     = is_mono ? ((wide_t'(s1_dl_q) + wide_t'(s1_dr_q)) >>> 1) : wide_t'(s1_dl_q);
    wr_l     = sat_sample(in_l + round_q15(wide_t'(fb_prod_l)));
    wr_r     = is_mono ? '0 :
               sat_sample(wide_t'(s1_dr_q) + round_q15(wide_t'(fb_prod_r)));
    we_r     = s1_valid_q && (!is_mono || !wrapped_q);
  end

  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (s1_valid_q) begin
      if (32'(wp_q) == MAX_DELAY - 1) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + ADDR_W'(1);
      end
    end
  end

  sfdm_ram #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SAMPLE_BITS)
  ) u_left_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (wp_q),
    .wdata_i (wr_l),
    .re_i    (in_fire),
    .raddr_i (raddr_l),
    .rdata_o (rdata_l)
  );

  sfdm_ram #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SAMPLE_BITS)
  ) u_right_line (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (wp_q),
    .wdata_i (wr_r),
    .re_i    (in_fire),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_pl_dry_q <= s1_dl_q * m_dry_s;
      s2_pl_wet_q <= tl * m_s;
      s2_pr_dry_q <= s1_dr_q * m_dry_s;
      s2_pr_wet_q <= tr * m_s;
    end
  end

  // Mix stage into the output register.
  assign s2_move = s2_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_valid_q) begin
      s2_valid_d = 1'b1;
    end else if (s2_move) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      left_out_q  <= sat_sample(round_q15(wide_t'(s2_pl_dry_q) + wide_t'(s2_pl_wet_q)));
      right_out_q <= sat_sample(round_q15(wide_t'(s2_pr_dry_q) + wide_t'(s2_pr_wet_q)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      s1_valid_q  <= in_fire;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the stereo feedback delay mix unit: directed and random stereo
// traffic under random sender bursts and receiver stalls.
// Depends on sfdm_pkg and stereo_feedback_delay_mix_unit.
`timescale 1ns / 1ps

module tb_top;
  import sfdm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = -24'sh800000;
  localparam longint Q15_ONE = 32768;
  localparam int REPORT_LIMIT = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } mixed_pair_t;

  class delay_mix_scoreboard;
    bit signed [SAMPLE_BITS-1:0] left_line[];
    bit signed [SAMPLE_BITS-1:0] right_line[];
    int unsigned write_ptr;
    int unsigned wraps;
    bit [MODE_W-1:0] routing;
    bit [DELAY_W-1:0] delay_l;
    bit [DELAY_W-1:0] delay_r;
    bit [GAIN_W-1:0] fb_gain;
    bit [GAIN_W-1:0] wet;
    mixed_pair_t expected_pairs[$];
    int checked;
    int errors;

    function new();
      left_line = new[MAX_DELAY];
      right_line = new[MAX_DELAY];
      write_ptr = 0;
      wraps = 0;
      routing = MODE_MONO;
      delay_l = 1;
      delay_r = 1;
      fb_gain = 0;
      wet = 0;
      checked = 0;
      errors = 0;
    endfunction

    function void configure(cfg_index_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_ROUTING_MODE: routing = value[MODE_W-1:0];
        CFG_DELAY_LEFT: delay_l = value[DELAY_W-1:0];
        CFG_DELAY_RIGHT: delay_r = value[DELAY_W-1:0];
        CFG_FEEDBACK_GAIN: fb_gain = value[GAIN_W-1:0];
        CFG_WET_MIX: wet = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned tap_of(bit [DELAY_W-1:0] d);
      int unsigned dd;
      dd = (d == 0) ? 1 : d;
      return (write_ptr + MAX_DELAY - dd) % MAX_DELAY;
    endfunction

    function longint q15_round(longint x);
      return (x + 64'sd16384) >>> 15;
    endfunction

    function sample_t clamp_q23(longint x);
      if (x > longint'(SAMPLE_MAX)) begin
        return SAMPLE_MAX;
      end
      if (x < longint'(SAMPLE_MIN)) begin
        return SAMPLE_MIN;
      end
      return x[SAMPLE_BITS-1:0];
    endfunction

    function sample_t crossfade(longint dry, longint tap, longint m);
      return clamp_q23(q15_round(dry * (Q15_ONE - m) + tap * m));
    endfunction

    function void note_input(sample_t dry_l, sample_t dry_r);
      longint in_l;
      longint in_r;
      longint tap_l;
      longint tap_r;
      longint g;
      longint m;
      mixed_pair_t want;
      in_l = dry_l;
      in_r = dry_r;
      g = (fb_gain > Q15_ONE) ? Q15_ONE : longint'(fb_gain);
      m = (wet > Q15_ONE) ? Q15_ONE : longint'(wet);
      tap_l = left_line[tap_of(delay_l)];
      if (routing == MODE_STEREO || routing == MODE_PING_PONG) begin
        tap_r = right_line[tap_of(delay_r)];
        if (routing == MODE_STEREO) begin
          left_line[write_ptr] = clamp_q23(in_l + q15_round(tap_l * g));
          right_line[write_ptr] = clamp_q23(in_r + q15_round(tap_r * g));
        end else begin
          left_line[write_ptr] = clamp_q23(in_l + q15_round(tap_r * g));
          right_line[write_ptr] = clamp_q23(in_r + q15_round(tap_l * g));
        end
      end else begin
        tap_r = tap_l;
        left_line[write_ptr] = clamp_q23(((in_l + in_r) >>> 1) + q15_round(tap_l * g));
      end
      write_ptr = (write_ptr + 1) % MAX_DELAY;
      if (write_ptr == 0) begin
        wraps++;
      end
      want.left = crossfade(in_l, tap_l, m);
      want.right = crossfade(in_r, tap_r, m);
      expected_pairs.push_back(want);
    endfunction

    function void check_result(sample_t got_l, sample_t got_r);
      mixed_pair_t want;
      if (expected_pairs.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Unexpected result with nothing outstanding: left %0d right %0d",
                   got_l, got_r);
        end
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (want.left !== got_l || want.right !== got_r) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Mismatch on result %0d: left expected %0d got %0d, right expected %0d got %0d",
                   checked, want.left, got_l, want.right, got_r);
        end
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t left_in = '0;
  sample_t right_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t left_out;
  sample_t right_out;

  delay_mix_scoreboard sb;
  int items_sent = 0;
  int settings_applied = 0;
  int idle_cycles = 0;
  int rx_style = 0;
  int rx_hold = 0;
  int rx_count = 0;

  stereo_feedback_delay_mix_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .left_out_o  (left_out),
    .right_out_o (right_out)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(left_out, right_out);
      end
      rx_count <= (rx_count + 1) % 29;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (rx_count >= rx_hold);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(MAX_DELAY - 1);
      2: return CFG_W'($urandom_range(1, MAX_DELAY - 1));
      default: return CFG_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(UNITY_GAIN);
      2: return CFG_W'($urandom_range(32769, 65535));
      3: return {2'($urandom_range(1, 3)), 16'($urandom())};
      default: return CFG_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] dl,
                               input logic [CFG_W-1:0] dr, input logic [CFG_W-1:0] fb,
                               input logic [CFG_W-1:0] mix);
    cfg_index_e order[5];
    logic [CFG_W-1:0] vals[5];
    order = '{CFG_ROUTING_MODE, CFG_DELAY_LEFT, CFG_DELAY_RIGHT, CFG_FEEDBACK_GAIN, CFG_WET_MIX};
    vals = '{CFG_W'(mode), dl, dr, fb, mix};
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      sb.configure(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_pair(input sample_t l, input sample_t r);
    left_in <= l;
    right_in <= r;
    in_valid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
    sb.note_input(l, r);
    items_sent++;
  endtask

  task automatic run_items(input int count, input bit with_gaps);
    int burst;
    burst = $urandom_range(1, 24);
    for (int k = 0; k < count; k++) begin
      send_pair(random_sample(), random_sample());
      burst--;
      if (with_gaps && burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst = $urandom_range(1, 24);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_random_until(input int target);
    logic [MODE_W-1:0] mode;
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 3) ? MODE_MONO : (pick < 6) ? MODE_STEREO :
             (pick < 9) ? MODE_PING_PONG : MODE_UNUSED;
      apply_setting(mode, random_delay(), random_delay(), random_gain(), random_gain());
      rx_style <= $urandom_range(0, 2);
      rx_hold <= $urandom_range(1, 20);
      run_items($urandom_range(15, 70), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Power-on settings: mono with no mix, so outputs equal the dry inputs.
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(-24'sd1, 24'sd0);
    send_pair(24'sd0, 24'sd0);
    in_valid <= 1'b0;

    // Unity feedback and fully wet output drive both lines into saturation.
    apply_setting(MODE_STEREO, 18'd1, 18'd2, CFG_W'(UNITY_GAIN), CFG_W'(UNITY_GAIN));
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(24'sd1, -24'sd1);
    in_valid <= 1'b0;

    // Zero delay acts as one; gains above unity are clamped.
    apply_setting(MODE_PING_PONG, 18'd0, 18'd1, 18'h0FFFF, 18'h08001);
    send_pair(SAMPLE_MAX, 24'sd0);
    send_pair(24'sd0, SAMPLE_MIN);
    send_pair(24'sd12345, -24'sd54321);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(-24'sd1, 24'sd1);
    in_valid <= 1'b0;

    // The unused routing code behaves as mono; upper write bits of a gain are dropped.
    apply_setting(MODE_UNUSED, 18'd3, CFG_W'(MAX_DELAY - 1), 18'd16384, 18'h34000);
    send_pair(24'sd3, 24'sd4);
    send_pair(-24'sd3, 24'sd0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, 24'sd1);
    send_pair(-24'sd8388607, -24'sd2);
    in_valid <= 1'b0;

    apply_setting(MODE_MONO, CFG_W'(MAX_DELAY - 1), 18'd5, 18'd32767, 18'd1);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(24'sd100, -24'sd101);
    in_valid <= 1'b0;

    run_random_until(RANDOM_ITEMS);

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);

    $display("Covered %0d transactions over %0d register settings.",
             items_sent, settings_applied);
    $display("Checked %0d results across %0d pointer wrap(s); %0d mismatch(es).",
             sb.checked, sb.wraps, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
